/* rtl/sha256h_pkg.sv */
package sha256h_pkg;

  // Payload widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned COUNT_W = 61;
  localparam int unsigned FILL_W  = 6;
  localparam int unsigned ROUND_W = 6;
  localparam int unsigned BLOCK_W = 512;

  typedef logic [WORD_W-1:0] word_t;

  // Padding constants
  localparam logic [BYTE_W-1:0] PAD_MARK     = 8'h80;
  localparam logic [FILL_W-1:0] LEN_OFFSET   = 6'd56;
  localparam logic [FILL_W-1:0] FILL_LAST    = 6'd63;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = 6'd63;
  localparam logic [IDX_W-1:0]  WORD_IDX_END = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_OUT
  } state_t;

  // Initial chaining words
  localparam word_t IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam word_t RC_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* rtl/sha256_stream_hasher_top.sv */
// Channel | Dir | tdata                   | tuser              | tlast
// in_     | in  | [7:0] data_byte         | [0] byte_present   | end_of_message
// out_    | out | [31:0] digest_word      | [2:0] word_index   | last_word
//
// A byte word is taken on the in_ handshake; the block is then busy whenever
// it completes a 64-byte block (64 rounds of the one round unit in S_ROUND,
// then S_ADD to fold into the chaining words). An end word adds the padding
// bytes (9 to 72), shifted in by S_PAD, plus the rounds and fold per block so
// closed, then the eight digest words, one per cycle while out_tready is high.
// Reset (rst_n low, synchronous) loads the initial chaining words.
// in_tready is low from acceptance until the work on that word is done.
module sha256_stream_hasher_top
  import sha256h_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic              in_tuser,   // [0] byte_present
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata,  // [31:0] digest_word
  output logic [IDX_W-1:0]  out_tuser,  // [2:0] word_index
  output logic              out_tlast
);

  state_t               state_r, state_nxt;
  logic [BLOCK_W-1:0]   blk_r, blk_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ROUND_W-1:0]   rnd_r, rnd_nxt;
  logic [IDX_W-1:0]     oidx_r, oidx_nxt;
  logic [IDX_W-1:0]     len_idx_r, len_idx_nxt;
  logic                 fin_r, fin_nxt;
  logic                 mark_r, mark_nxt;
  logic                 len_act_r, len_act_nxt;
  logic                 pad_done_r, pad_done_nxt;
  word_t                h_r [8];
  word_t                h_nxt [8];
  word_t                v_r [8];
  word_t                v_nxt [8];

  logic                 in_fire, out_fire;
  logic                 len_byte;
  logic [BYTE_W-1:0]    pad_byte;
  word_t                w_cur, w_new, t1, t2, ch, maj;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Padding byte choice: marker, zeros, then the bit length high byte first
  assign len_byte = mark_r && (len_act_r || (fill_r == LEN_OFFSET));
  always_comb begin
    if (!mark_r) begin
      pad_byte = PAD_MARK;
    end else if (len_byte) begin
      pad_byte = cnt_r[COUNT_W-1 -: BYTE_W];
    end else begin
      pad_byte = '0;
    end
  end

  // Round unit and rolling schedule
  assign w_cur = blk_r[BLOCK_W-1 -: WORD_W];
  assign ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1    = v_r[7] + big_sig1(v_r[4]) + ch + RC_TAB[rnd_r] + w_cur;
  assign t2    = big_sig0(v_r[0]) + maj;
  assign w_new = w_cur
               + small_sig0(blk_r[BLOCK_W-WORD_W-1 -: WORD_W])
               + blk_r[BLOCK_W-9*WORD_W-1 -: WORD_W]
               + small_sig1(blk_r[BLOCK_W-14*WORD_W-1 -: WORD_W]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser && (fill_r == FILL_LAST)) begin
            state_nxt = S_ROUND;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_ROUND: begin
        if (rnd_r == ROUND_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (pad_done_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        if (fill_r == FILL_LAST) begin
          state_nxt = S_ROUND;
        end
      end
      S_OUT: begin
        if (out_fire && (oidx_r == WORD_IDX_END)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    out_tdata  = h_r[oidx_r];
    out_tuser  = oidx_r;
    out_tlast  = (oidx_r == WORD_IDX_END);
  end

  // Datapath updates
  always_comb begin
    blk_nxt      = blk_r;
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    rnd_nxt      = rnd_r;
    oidx_nxt     = oidx_r;
    len_idx_nxt  = len_idx_r;
    fin_nxt      = fin_r;
    mark_nxt     = mark_r;
    len_act_nxt  = len_act_r;
    pad_done_nxt = pad_done_r;
    h_nxt        = h_r;
    v_nxt        = v_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          fin_nxt = in_tlast;
          if (in_tuser) begin
            blk_nxt  = {blk_r[BLOCK_W-BYTE_W-1:0], in_tdata};
            fill_nxt = fill_r + 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            v_nxt    = h_r;
          end
        end
      end
      S_ROUND: begin
        for (int i = 7; i > 0; i--) begin
          v_nxt[i] = v_r[i-1];
        end
        v_nxt[4] = v_r[3] + t1;
        v_nxt[0] = t1 + t2;
        blk_nxt  = {blk_r[BLOCK_W-WORD_W-1:0], w_new};
        rnd_nxt  = rnd_r + 1'b1;
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
      end
      S_PAD: begin
        blk_nxt  = {blk_r[BLOCK_W-BYTE_W-1:0], pad_byte};
        fill_nxt = fill_r + 1'b1;
        v_nxt    = h_r;
        mark_nxt = 1'b1;
        if (len_byte) begin
          len_act_nxt = 1'b1;
          cnt_nxt     = cnt_r << BYTE_W;
          len_idx_nxt = len_idx_r + 1'b1;
          if (len_idx_r == WORD_IDX_END) begin
            pad_done_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_fire) begin
          oidx_nxt = oidx_r + 1'b1;
          if (oidx_r == WORD_IDX_END) begin
            // digest delivered: back to the start of a new message
            h_nxt        = IV_TAB;
            cnt_nxt      = '0;
            fill_nxt     = '0;
            fin_nxt      = 1'b0;
            mark_nxt     = 1'b0;
            len_act_nxt  = 1'b0;
            len_idx_nxt  = '0;
            pad_done_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      cnt_r      <= '0;
      rnd_r      <= '0;
      oidx_r     <= '0;
      len_idx_r  <= '0;
      fin_r      <= 1'b0;
      mark_r     <= 1'b0;
      len_act_r  <= 1'b0;
      pad_done_r <= 1'b0;
      h_r        <= IV_TAB;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      cnt_r      <= cnt_nxt;
      rnd_r      <= rnd_nxt;
      oidx_r     <= oidx_nxt;
      len_idx_r  <= len_idx_nxt;
      fin_r      <= fin_nxt;
      mark_r     <= mark_nxt;
      len_act_r  <= len_act_nxt;
      pad_done_r <= pad_done_nxt;
      h_r        <= h_nxt;
    end
  end

  // Block window and working words
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    v_r   <= v_nxt;
  end

endmodule
